[rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SMTG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smtg assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define SMTG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smtg assertion failed");

`endif

[rtl/smtg_pkg.sv]
// Package: constants, types and control struct of the median temperature guard
package smtg_pkg;

    // Window length and median position
    localparam int WINDOW     = 9;
    localparam int MEDIAN_IDX = WINDOW / 2;

    // Field widths
    localparam int RAW_W   = 10;
    localparam int SCALE_W = 16;
    localparam int TEMP_W  = 26;

    // Rank counter holds 0..WINDOW
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int STEP_W = $clog2(WINDOW + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = TEMP_W;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHUTOFF_LEVEL = 2'd1;

    localparam logic [SCALE_W-1:0] SCALE_RESET   = 16'd4096;
    localparam logic [TEMP_W-1:0]  SHUTOFF_RESET = 26'd163840;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LOAD,
        S_RANK,
        S_SEL
    } t_state;

    // Control broadcast to every cell
    typedef struct packed {
        logic shift;
        logic fill;
        logic rank;
    } t_cell_ctrl;

endpackage

[rtl/smtg_in_if.sv]
// Input channel: one raw converter sample per item
interface smtg_in_if;
    import smtg_pkg::*;

    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

[rtl/smtg_out_if.sv]
// Output channel: median temperature and safe flag per item
interface smtg_out_if;
    import smtg_pkg::*;

    logic              valid;
    logic              ready;
    logic [TEMP_W-1:0] median_temp;
    logic              is_safe;

    modport source (output valid, output median_temp, output is_safe, input ready);
    modport sink   (input valid, input median_temp, input is_safe, output ready);
endinterface

[rtl/smtg_cell.sv]
// One window cell: holds a value, passes a probe ring along, counts its rank
module smtg_cell import smtg_pkg::*; (
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [TEMP_W-1:0] i_shift_in,
    input  logic [TEMP_W-1:0] i_fill_value,
    input  logic [TEMP_W-1:0] i_ring,
    output logic [TEMP_W-1:0] o_value,
    output logic [TEMP_W-1:0] o_ring,
    output logic              o_hit
);

    logic [TEMP_W-1:0] r_value;
    logic [TEMP_W-1:0] r_ring;
    logic [CNT_W-1:0]  r_lt;
    logic [CNT_W-1:0]  r_le;
    logic [TEMP_W-1:0] n_value;

    // First item after reset fills every cell, later ones shift
    always_comb begin
        n_value = i_ctrl.fill ? i_fill_value : i_shift_in;
    end

    // Shift loads value and probe copy; rank compares against passing probe
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_value <= n_value;
            r_ring  <= n_value;
            r_lt    <= '0;
            r_le    <= '0;
        end else if (i_ctrl.rank) begin
            if (r_ring < r_value) begin
                r_lt <= r_lt + CNT_W'(1);
            end
            if (r_ring <= r_value) begin
                r_le <= r_le + CNT_W'(1);
            end
            r_ring <= i_ring;
        end
    end

    // Value is the median when fewer than or equal MEDIAN_IDX lie below it
    // and more than MEDIAN_IDX lie at or below it
    assign o_hit   = (r_lt <= CNT_W'(MEDIAN_IDX)) && (r_le > CNT_W'(MEDIAN_IDX));
    assign o_value = r_value;
    assign o_ring  = r_ring;

endmodule

[rtl/smtg_chain.sv]
// Row of window cells with a rotating probe ring and median pick
module smtg_chain import smtg_pkg::*; (
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [TEMP_W-1:0] i_new_value,
    output logic [TEMP_W-1:0] o_median
);

    logic [TEMP_W-1:0] w_value [WINDOW];
    logic [TEMP_W-1:0] w_ring  [WINDOW];
    logic [WINDOW-1:0] w_hit;

    // Cells: value shifts toward the old end, probes rotate around the ring
    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        smtg_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (i_ctrl),
            .i_shift_in   ((g == 0) ? i_new_value : w_value[(g == 0) ? 0 : g - 1]),
            .i_fill_value (i_new_value),
            .i_ring       (w_ring[(g == 0) ? WINDOW - 1 : g - 1]),
            .o_value      (w_value[g]),
            .o_ring       (w_ring[g]),
            .o_hit        (w_hit[g])
        );
    end

    // All hitting cells hold the same value, so an OR merge picks it
    always_comb begin
        o_median = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if (w_hit[i]) begin
                o_median = o_median | w_value[i];
            end
        end
    end

endmodule

[rtl/sliding_median_temperature_guard_core.sv]
// Per item: S_IDLE accepts a sample, S_MUL scales it, S_LOAD shifts it in, S_RANK turns
// the probe ring once through the cell chain to rank every window value, S_SEL waits
// for a free output. No new sample is taken until the previous result is registered.
// Reset: synchronous, active low; clears the sequencer, output valid and primed
// flag and restores scale_factor = 1.0 (Q4.12) and shutoff_level = 40 degrees.
module sliding_median_temperature_guard_core import smtg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    smtg_in_if.sink               i_in,
    smtg_out_if.source            o_out
);

    t_state            r_state;
    t_state            n_state;
    logic [SCALE_W-1:0] r_scale;
    logic [TEMP_W-1:0] r_shutoff;
    logic [RAW_W-1:0]  r_raw;
    logic [TEMP_W-1:0] r_scaled;
    logic [STEP_W-1:0] r_step;
    logic              r_primed;
    logic              r_out_valid;
    logic [TEMP_W-1:0] r_median;
    logic              r_safe;

    logic              w_in_acc;
    logic              w_out_free;
    logic              w_load_out;
    logic [TEMP_W-1:0] w_prod;
    logic [TEMP_W-1:0] w_median;
    t_cell_ctrl        w_ctrl;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    // Exact 10x16 product, always below 2^26
    assign w_prod = {{(TEMP_W - RAW_W){1'b0}}, r_raw} * {{(TEMP_W - SCALE_W){1'b0}}, r_scale};

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale   <= SCALE_RESET;
            r_shutoff <= SHUTOFF_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SCALE_FACTOR:  r_scale   <= i_cfg_data[SCALE_W-1:0];
                REG_SHUTOFF_LEVEL: r_shutoff <= i_cfg_data[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and cell control
    always_comb begin
        n_state      = r_state;
        i_in.ready   = 1'b0;
        w_load_out   = 1'b0;
        w_ctrl.shift = 1'b0;
        w_ctrl.fill  = !r_primed;
        w_ctrl.rank  = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                w_ctrl.shift = 1'b1;
                n_state      = S_RANK;
            end
            S_RANK: begin
                w_ctrl.rank = 1'b1;
                if (r_step == STEP_W'(WINDOW - 1)) begin
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath: sample capture, scaling, ring step count
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_raw <= i_in.raw_sample;
        end
        if (r_state == S_MUL) begin
            r_scaled <= w_prod;
        end
        if (r_state == S_LOAD) begin
            r_step <= '0;
        end else if (r_state == S_RANK) begin
            r_step <= r_step + STEP_W'(1);
        end
    end

    // Primed flag: set once the first item has filled the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
        end else if (r_state == S_LOAD) begin
            r_primed <= 1'b1;
        end
    end

    smtg_chain u_chain (
        .i_clk       (i_clk),
        .i_ctrl      (w_ctrl),
        .i_new_value (r_scaled),
        .o_median    (w_median)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_median <= w_median;
            r_safe   <= (w_median < r_shutoff);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.median_temp = r_median;
    assign o_out.is_safe     = r_safe;

endmodule

[rtl/smtg_checker.sv]
// Port checker for the median temperature guard, bound to the top level
`include "assert_macros.svh"

module smtg_checker import smtg_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [TEMP_W-1:0] i_median_temp,
    input logic              i_is_safe
);

    logic w_in_acc;
    logic w_out_stall;

    assign w_in_acc    = i_in_valid && i_in_ready;
    assign w_out_stall = i_out_valid && !i_out_ready;

    // One item at a time, and no result shows up right behind an accept
    `SMTG_ASSERT_NXT(a_in_busy, i_clk, i_rst_n, w_in_acc, !i_in_ready && !$rose(i_out_valid))
    `SMTG_ASSERT_IMP(a_no_early_result, i_clk, i_rst_n, w_in_acc, ##2 !$rose(i_out_valid))

    // Stalled result holds
    `SMTG_ASSERT_NXT(a_out_valid_holds, i_clk, i_rst_n, w_out_stall, i_out_valid)
    `SMTG_ASSERT_NXT(a_median_holds, i_clk, i_rst_n, w_out_stall, $stable(i_median_temp))
    `SMTG_ASSERT_NXT(a_safe_holds, i_clk, i_rst_n, w_out_stall, $stable(i_is_safe))

endmodule

bind sliding_median_temperature_guard_core smtg_checker u_smtg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_median_temp (o_out.median_temp),
    .i_is_safe     (o_out.is_safe)
);
